// ===== rtl/hcsa_pkg.sv =====
// shared widths and constants for the hash chain segment address block
// used by every module under rtl; no dependencies
package hcsa_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned SEG_W   = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned DIV_CNT_W = $clog2(KEY_W);

  localparam logic [KEY_W-1:0] FNV_OFFSET_BASIS = 32'h811C_9DC5;
  localparam logic [KEY_W-1:0] FNV_PRIME        = 32'h0100_0193;
  localparam logic [KEY_W-1:0] BUCKET_RESET     = 32'h0010_0000;

endpackage

// ===== rtl/hash_chain_segment_address_top.sv =====
// hash chain segment address: fnv-1a chain steps, then fold into a bucket address
// depends on hcsa_pkg, hcsa_fnv_round, hcsa_mod_unit
// one byte round per cycle through one shared fnv round, then a bit-serial restoring remainder
// one item at a time: busy is low in the strobe cycle, so the next beat can already be taken in the strobe cycle
// reset clears the sequencer and sets bucket_count to 1048576; results cannot be stalled
module hash_chain_segment_address_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [hcsa_pkg::KEY_W-1:0] file_key_i,
  input  logic [hcsa_pkg::SEG_W-1:0] segment_index_i,
  input  logic                       cfg_we_i,
  input  logic [hcsa_pkg::KEY_W-1:0] cfg_wdata_i,
  output logic                       result_valid_o,
  output logic [hcsa_pkg::KEY_W-1:0] chained_key_o,
  output logic [hcsa_pkg::KEY_W-1:0] bucket_address_o,
  output logic                       probe_up_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_LOAD,
    ST_DIV
  } state_e;

  state_e                     state_q, state_d;
  logic [hcsa_pkg::KEY_W-1:0] bucket_q, bucket_d;
  logic [hcsa_pkg::KEY_W-1:0] key_q, key_d;
  logic [hcsa_pkg::KEY_W-1:0] h_q, h_d;
  logic [hcsa_pkg::SEG_W-1:0] steps_q, steps_d;
  logic [1:0]                 byte_q, byte_d;
  logic                       valid_q, valid_d;
  logic [hcsa_pkg::KEY_W-1:0] ckey_q, ckey_d;
  logic [hcsa_pkg::KEY_W-1:0] addr_q, addr_d;
  logic                       probe_q, probe_d;

  logic                        accept;
  logic [hcsa_pkg::KEY_W-1:0]  round_in;
  logic [hcsa_pkg::KEY_W-1:0]  round_out;
  logic [hcsa_pkg::BYTE_W-1:0] round_byte;
  logic [hcsa_pkg::KEY_W-1:0]  modulus;
  logic                        div_start;
  logic                        div_done;
  logic [hcsa_pkg::KEY_W-1:0]  div_rem;

  assign accept = start && !busy;

  // each chain step seeds from its key, or the offset basis for a zero key
  assign round_in   = (byte_q != 2'd0) ? h_q :
                      (key_q == '0) ? hcsa_pkg::FNV_OFFSET_BASIS : key_q;
  assign round_byte = key_q[{byte_q, 3'b000} +: hcsa_pkg::BYTE_W];

  hcsa_fnv_round u_round (
    .h_i    (round_in),
    .data_i (round_byte),
    .h_o    (round_out)
  );

  // counts below two behave as two, giving modulus one
  assign modulus   = (bucket_q[hcsa_pkg::KEY_W-1:1] == '0) ? {{(hcsa_pkg::KEY_W-1){1'b0}}, 1'b1}
                                                           : bucket_q - 1'b1;
  assign div_start = (state_q == ST_LOAD);

  hcsa_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (key_q),
    .modulus_i  (modulus),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  always_comb begin
    state_d  = state_q;
    bucket_d = cfg_we_i ? cfg_wdata_i : bucket_q;
    key_d    = key_q;
    h_d      = h_q;
    steps_d  = steps_q;
    byte_d   = byte_q;
    valid_d  = 1'b0;
    ckey_d   = ckey_q;
    addr_d   = addr_q;
    probe_d  = probe_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          key_d   = file_key_i;
          steps_d = segment_index_i;
          byte_d  = 2'd0;
          state_d = (segment_index_i == '0) ? ST_LOAD : ST_ROUND;
        end
      end
      ST_ROUND: begin
        h_d    = round_out;
        byte_d = byte_q + 1'b1;
        if (byte_q == 2'd3) begin
          key_d   = round_out;
          steps_d = steps_q - 1'b1;
          if (steps_q == {{(hcsa_pkg::SEG_W-1){1'b0}}, 1'b1}) begin
            state_d = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          ckey_d  = key_q;
          addr_d  = div_rem + 1'b1;
          probe_d = div_rem[0] ^ 1'b1;
          valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      bucket_q <= hcsa_pkg::BUCKET_RESET;
      steps_q  <= '0;
      byte_q   <= 2'd0;
      valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      bucket_q <= bucket_d;
      steps_q  <= steps_d;
      byte_q   <= byte_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    h_q     <= h_d;
    ckey_q  <= ckey_d;
    addr_q  <= addr_d;
    probe_q <= probe_d;
  end

  assign busy             = (state_q != ST_IDLE);
  assign result_valid_o   = valid_q;
  assign chained_key_o    = ckey_q;
  assign bucket_address_o = addr_q;
  assign probe_up_o       = probe_q;

  a_strobe_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (state_q == ST_IDLE) ##1 !result_valid_o)
    else $error("result beat not a single strobe at the end of an item");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy && !result_valid_o)
    else $error("accepted beat did not raise busy");

  a_round_steps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) |-> (steps_q != '0))
    else $error("hash round running with no chain steps left");

  a_addr_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (bucket_address_o != '0)
                       && (probe_up_o == bucket_address_o[0]))
    else $error("bucket address zero or probe direction mismatch");

endmodule

// ===== rtl/hcsa_fnv_round.sv =====
// one fnv-1a byte round: xor a byte into the hash, multiply by the prime mod 2^32
// depends on hcsa_pkg
module hcsa_fnv_round (
  input  logic [hcsa_pkg::KEY_W-1:0]  h_i,
  input  logic [hcsa_pkg::BYTE_W-1:0] data_i,
  output logic [hcsa_pkg::KEY_W-1:0]  h_o
);

  logic [hcsa_pkg::KEY_W-1:0] mixed;

  assign mixed = h_i ^ {{(hcsa_pkg::KEY_W-hcsa_pkg::BYTE_W){1'b0}}, data_i};
  // 32-bit context keeps only the low word of the product
  assign h_o   = mixed * hcsa_pkg::FNV_PRIME;

endmodule

// ===== rtl/hcsa_mod_unit.sv =====
// iterative remainder unit, one dividend bit per cycle (restoring)
// depends on hcsa_pkg
module hcsa_mod_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [hcsa_pkg::KEY_W-1:0] dividend_i,
  input  logic [hcsa_pkg::KEY_W-1:0] modulus_i,
  output logic                       done_o,
  output logic [hcsa_pkg::KEY_W-1:0] rem_o
);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [hcsa_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [hcsa_pkg::KEY_W-1:0]     dvd_q, dvd_d;
  logic [hcsa_pkg::KEY_W-1:0]     mod_q, mod_d;
  logic [hcsa_pkg::KEY_W-1:0]     rem_q, rem_d;
  logic [hcsa_pkg::KEY_W:0]       rem_shift;
  logic [hcsa_pkg::KEY_W+1:0]     diff;

  assign rem_shift = {rem_q, dvd_q[hcsa_pkg::KEY_W-1]};
  assign diff      = {1'b0, rem_shift} - {2'b00, mod_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    mod_d  = mod_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      mod_d  = modulus_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[hcsa_pkg::KEY_W-2:0], 1'b0};
      // subtract when the shifted remainder reaches the modulus
      rem_d = diff[hcsa_pkg::KEY_W+1] ? rem_shift[hcsa_pkg::KEY_W-1:0]
                                      : diff[hcsa_pkg::KEY_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == {hcsa_pkg::DIV_CNT_W{1'b1}}) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    mod_q <= mod_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("remainder unit started while busy");

  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q ##1 !done_q)
    else $error("remainder done not a single pulse after the last step");

  a_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q || done_q) |-> (rem_q < mod_q))
    else $error("partial remainder reached the modulus");

endmodule

// ===== test/tb_top.sv =====
// self-checking bench for hash_chain_segment_address_top: directed table, then random phases
// scores every result beat against a typed table expectation or a built-in fnv-1a chain and bucket fold predictor
// depends on rtl/hcsa_pkg.sv and rtl/hash_chain_segment_address_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [hcsa_pkg::KEY_W-1:0] key_t;
  typedef logic [hcsa_pkg::SEG_W-1:0] seg_t;

  typedef struct packed {
    key_t chained;
    key_t addr;
    logic probe;
  } address_beat_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e     kind;
    key_t          key;
    seg_t          seg;
    logic          typed;
    address_beat_t want;
  } dir_row_t;

  localparam int DIR_ROWS        = 23;
  localparam int RAND_PHASES     = 10;
  localparam int ITEMS_PER_PHASE = 163;
  localparam int DRAIN_CYCLES    = 100;
  localparam int REPORT_MAX      = 10;
  // long enough to outlast one max-length chain
  localparam int WATCHDOG_LIMIT  = 800_000;

  // typed expectations only for rows with no chain step
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{ROW_ITEM, 32'h0000_0005, 16'd0,      1'b1, '{32'h0000_0005, 32'd6,    1'b0}},
    '{ROW_ITEM, 32'h0000_0000, 16'd0,      1'b1, '{32'h0000_0000, 32'd1,    1'b1}},
    '{ROW_ITEM, 32'hFFFF_FFFF, 16'd0,      1'b1, '{32'hFFFF_FFFF, 32'd4096, 1'b0}},
    '{ROW_ITEM, 32'h0000_0000, 16'd1,      1'b0, '0},
    '{ROW_ITEM, 32'h0000_0000, 16'd2,      1'b0, '0},
    '{ROW_ITEM, 32'hFFFF_FFFF, 16'd1,      1'b0, '0},
    '{ROW_ITEM, 32'h0000_0100, 16'd3,      1'b0, '0},
    '{ROW_ITEM, 32'hDEAD_BEEF, 16'hFFFF,   1'b0, '0},
    '{ROW_CFG,  32'h0000_0000, 16'd0,      1'b0, '0},
    '{ROW_ITEM, 32'h1234_5678, 16'd0,      1'b1, '{32'h1234_5678, 32'd1,    1'b1}},
    '{ROW_ITEM, 32'h0000_0000, 16'd7,      1'b0, '0},
    '{ROW_CFG,  32'h0000_0001, 16'd0,      1'b0, '0},
    '{ROW_ITEM, 32'hFFFF_FFFF, 16'd0,      1'b1, '{32'hFFFF_FFFF, 32'd1,    1'b1}},
    '{ROW_CFG,  32'h0000_0002, 16'd0,      1'b0, '0},
    '{ROW_ITEM, 32'hA5A5_A5A5, 16'd5,      1'b0, '0},
    '{ROW_CFG,  32'hFFFF_FFFF, 16'd0,      1'b0, '0},
    '{ROW_ITEM, 32'hFFFF_FFFF, 16'd0,      1'b1, '{32'hFFFF_FFFF, 32'd2,    1'b0}},
    '{ROW_ITEM, 32'hFFFF_FFFE, 16'd0,      1'b1, '{32'hFFFF_FFFE, 32'd1,    1'b1}},
    '{ROW_ITEM, 32'h0000_0000, 16'd0,      1'b1, '{32'h0000_0000, 32'd1,    1'b1}},
    '{ROW_ITEM, 32'h5A5A_5A5A, 16'd12,     1'b0, '0},
    '{ROW_CFG,  32'h0000_0003, 16'd0,      1'b0, '0},
    '{ROW_ITEM, 32'h0000_0007, 16'd0,      1'b1, '{32'h0000_0007, 32'd2,    1'b0}},
    '{ROW_ITEM, 32'h8000_0000, 16'd4,      1'b0, '0}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  key_t file_key_i      = '0;
  seg_t segment_index_i = '0;
  logic cfg_we_i        = 1'b0;
  key_t cfg_wdata_i     = '0;
  logic result_valid_o;
  key_t chained_key_o;
  key_t bucket_address_o;
  logic probe_up_o;

  // expectation typed into the table for the beat being offered
  logic          typed_row  = 1'b0;
  address_beat_t typed_want = '0;

  address_beat_t address_fifo[$];
  key_t bucket_model   = hcsa_pkg::BUCKET_RESET;
  int   items_sent     = 0;
  int   results_seen   = 0;
  int   mismatch_cnt   = 0;
  int   cfg_writes     = 0;
  int   longest_chain  = 0;
  int   directed_items = 0;
  bit   burst          = 1'b0;

  hash_chain_segment_address_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .file_key_i      (file_key_i),
    .segment_index_i (segment_index_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .result_valid_o  (result_valid_o),
    .chained_key_o   (chained_key_o),
    .bucket_address_o(bucket_address_o),
    .probe_up_o      (probe_up_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic address_beat_t predict_segment_address(key_t key, seg_t steps,
                                                            key_t buckets);
    key_t          h;
    key_t          acc;
    key_t          modulus;
    address_beat_t r;
    h = key;
    for (int s = 0; s < int'(steps); s++) begin
      // a zero key only swaps the seed, its four zero bytes are still hashed
      acc = (h == '0) ? hcsa_pkg::FNV_OFFSET_BASIS : h;
      for (int b = 0; b < 4; b++) begin
        acc = (acc ^ {24'd0, h[hcsa_pkg::BYTE_W*b +: hcsa_pkg::BYTE_W]})
              * hcsa_pkg::FNV_PRIME;
      end
      h = acc;
    end
    modulus   = (buckets < 2) ? key_t'(1) : buckets - 1;
    r.chained = h;
    r.addr    = h % modulus + 1;
    r.probe   = r.addr[0];
    return r;
  endfunction

  always @(posedge clk_i) begin : address_scoreboard
    address_beat_t got;
    address_beat_t want;
    if (rst_ni) begin
      // the strobe beat belongs to the previous item, so score it before queueing a new one
      if (result_valid_o) begin
        results_seen++;
        got = '{chained_key_o, bucket_address_o, probe_up_o};
        if (address_fifo.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX)
            $display("unexpected beat: chained_key %h bucket_address %h probe_up %b",
                     got.chained, got.addr, got.probe);
        end else begin
          want = address_fifo.pop_front();
          if (got.chained !== want.chained || got.addr !== want.addr ||
              got.probe !== want.probe) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_MAX)
              $display("beat %0d: chained_key %h/%h bucket_address %h/%h probe_up %b/%b",
                       results_seen, want.chained, got.chained, want.addr, got.addr,
                       want.probe, got.probe);
          end
        end
      end
      if (cfg_we_i) begin
        bucket_model = cfg_wdata_i;
        cfg_writes++;
      end
      if (start && !busy) begin
        if (typed_row)
          address_fifo.push_back(typed_want);
        else
          address_fifo.push_back(predict_segment_address(file_key_i, segment_index_i,
                                                         bucket_model));
        if (int'(segment_index_i) > longest_chain)
          longest_chain = int'(segment_index_i);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || result_valid_o || (start && !busy))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // offer one item, hold it until taken and busy drops, then idle for a random stretch or none
  task automatic send_item(key_t key, seg_t seg, logic typed, address_beat_t want);
    int gap;
    int pick;
    file_key_i      <= key;
    segment_index_i <= seg;
    typed_row       <= typed;
    typed_want      <= want;
    start           <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
    pick = $urandom_range(0, 99);
    if (burst || pick < 50)
      gap = 0;
    else if (pick < 85)
      gap = $urandom_range(1, 4);
    else if (pick < 97)
      gap = $urandom_range(5, 40);
    else
      gap = $urandom_range(41, 300);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // the register may only change once every outstanding beat has come back
  task automatic write_bucket_count(key_t value);
    start <= 1'b0;
    while (results_seen != items_sent) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin : stimulus
    key_t key;
    seg_t seg;
    key_t buckets;
    int   pick;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIR_TABLE[i].kind == ROW_CFG) begin
        write_bucket_count(DIR_TABLE[i].key);
      end else begin
        send_item(DIR_TABLE[i].key, DIR_TABLE[i].seg, DIR_TABLE[i].typed, DIR_TABLE[i].want);
        directed_items++;
      end
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        1:       buckets = 32'd2;
        2:       buckets = 32'hFFFF_FFFF;
        3:       buckets = $urandom_range(2, 64);
        4:       buckets = 32'd0;
        5:       buckets = 32'd3;
        6:       buckets = 32'h8000_0001;
        8:       buckets = 32'd1;
        9:       buckets = $urandom_range(2, 65536);
        default: buckets = $urandom;
      endcase
      write_bucket_count(buckets);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 49) == 0) burst = !burst;
        case ($urandom_range(0, 15))
          0:       key = '0;
          1:       key = '1;
          2:       key = key_t'(1) << $urandom_range(0, hcsa_pkg::KEY_W-1);
          3:       key = $urandom_range(0, 255);
          default: key = $urandom;
        endcase
        // chains are slow, so most are short and only a few run long
        pick = $urandom_range(0, 999);
        if (pick < 700)
          seg = seg_t'($urandom_range(0, 3));
        else if (pick < 950)
          seg = seg_t'($urandom_range(4, 40));
        else if (pick < 997)
          seg = seg_t'($urandom_range(41, 600));
        else
          seg = seg_t'($urandom_range(601, 4095));
        send_item(key, seg, 1'b0, '0);
      end
    end

    start <= 1'b0;
    while (results_seen != items_sent) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (address_fifo.size() != 0) begin
      $display("%0d expected beats never arrived", address_fifo.size());
      mismatch_cnt += address_fifo.size();
    end

    $display("run covered %0d items (%0d from the table), %0d bucket count writes,",
             items_sent, directed_items, cfg_writes);
    $display("chains up to %0d steps; %0d beats scored, %0d mismatches",
             longest_chain, results_seen, mismatch_cnt);
    if (mismatch_cnt == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
